/* hw/rtl/battery_median_gauge_unit_macros.svh */
// Assertion macros shared by the battery median gauge RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef BATTERY_MEDIAN_GAUGE_UNIT_MACROS_SVH
`define BATTERY_MEDIAN_GAUGE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bmg_pkg.sv */
// Package of the battery median gauge: field widths, register indexes and
// reset values. Used by the interfaces, the divider and the top level.
package bmg_pkg;
	localparam int CODE_BITS = 12;
	localparam int PCT_BITS = 7;
	localparam int REG_IDX_BITS = 2;
	localparam int NUM_BITS = CODE_BITS + PCT_BITS;
	localparam logic [PCT_BITS-1:0] PERCENT_MAX = 7'd100;
	localparam logic [CODE_BITS-1:0] RESET_EMPTY = 12'd1800;
	localparam logic [CODE_BITS-1:0] RESET_FULL = 12'd2360;
	localparam logic [REG_IDX_BITS-1:0] REG_EMPTY_CODE = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_FULL_CODE = 2'd1;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [PCT_BITS-1:0] pct_t;
	typedef logic [NUM_BITS-1:0] num_t;
endpackage

/* hw/rtl/bmg_if.sv */
// Valid/ready channel interfaces of the battery median gauge.
// Depends on bmg_pkg for the payload types.
interface bmg_sample_if;
	logic valid;
	logic ready;
	bmg_pkg::code_t sample_code;
	modport source (output valid, output sample_code, input ready);
	modport sink (input valid, input sample_code, output ready);
endinterface

interface bmg_gauge_if;
	logic valid;
	logic ready;
	bmg_pkg::code_t median_code;
	bmg_pkg::pct_t charge_percent;
	modport source (output valid, output median_code, output charge_percent, input ready);
	modport sink (input valid, input median_code, input charge_percent, output ready);
endinterface

/* hw/rtl/bmg_div.sv */
// Restoring divider that yields a percentage quotient, one bit per cycle.
// Depends on bmg_pkg. The caller guarantees the quotient is below 2**PCT_BITS.
module bmg_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bmg_pkg::num_t  num,
	input  bmg_pkg::code_t den,
	output logic           done,
	output bmg_pkg::pct_t  quo
);
	import bmg_pkg::*;

	localparam int STEP_BITS = $clog2(PCT_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	num_t                 rem_q;
	num_t                 dsh_q;
	pct_t                 quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(PCT_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NUM_BITS'(den) << (PCT_BITS - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[PCT_BITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[PCT_BITS-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

/* hw/rtl/battery_median_gauge_unit.sv */
// Battery median gauge: each sample transaction overwrites the oldest entry
// of a ring of the last WINDOW samples (all zero after reset), and one result
// transaction follows with the ring median (sorted element WINDOW/2) and a
// charge percentage mapped linearly from empty_code..full_code onto 0..100,
// truncated and clamped. One item is worked on at a time, and no new sample is
// taken while a result is held. When the percentage is clamped to zero or to
// the maximum, the divider is skipped. The median is found by a radix select
// that sweeps the whole ring memory once per sample bit through its single
// read port. The divider retires one quotient bit per cycle. A result that
// waits for gauge.ready holds off the next sample. Configuration writes take
// effect at once and must be made while no item is in flight. Depends on
// bmg_pkg, bmg_if, bmg_div and the macros header.
`include "battery_median_gauge_unit_macros.svh"

module battery_median_gauge_unit #(
	parameter int WINDOW = 50,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bmg_pkg::REG_IDX_BITS-1:0]   wr_index,
	input  bmg_pkg::code_t                     wr_data,
	bmg_sample_if.sink                         samples,
	bmg_gauge_if.source                        gauge
);
	import bmg_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int CMP_W = (SAMPLE_BITS > CODE_BITS) ? SAMPLE_BITS : CODE_BITS;
	localparam logic [CW-1:0] RANK = CW'(WINDOW / 2);
	localparam logic [CW-1:0] LAST_ADDR = CW'(WINDOW);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_DIV, ST_OUT} state_t;

	state_t                 state_q;
	logic [AW-1:0]          slot_q;
	logic [WINDOW-1:0]      valid_q;
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
	code_t                  empty_q;
	code_t                  full_q;

	// Scan registers of the radix select.
	logic [CW-1:0]          addr_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          rank_q;
	logic [SAMPLE_BITS-1:0] prefix_q;
	logic [SAMPLE_BITS-1:0] mask_q;
	logic [SAMPLE_BITS-1:0] bit_q;
	logic [SAMPLE_BITS-1:0] rd_s1;
	logic                   rdv_s1;
	logic                   scan_s1;

	logic  out_vld_q;
	code_t median_q;
	pct_t  pct_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] elem;
	logic                   hit;
	logic [CW-1:0]          total;
	logic [CMP_W-1:0]       med_ext;
	logic [CMP_W-1:0]       lo_ext;
	logic [CMP_W-1:0]       hi_ext;
	code_t                  diff;
	num_t                   numer;
	logic                   div_start;
	logic                   div_done;
	pct_t                   div_quo;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);

	// An entry never written since reset counts as zero.
	assign elem = rdv_s1 ? rd_s1 : '0;
	assign hit = scan_s1 && (((elem ^ prefix_q) & mask_q) == '0) && ((elem & bit_q) == '0);
	assign total = cnt_q + CW'(hit);

	assign med_ext = CMP_W'(prefix_q);
	assign lo_ext = CMP_W'(empty_q);
	assign hi_ext = CMP_W'(full_q);
	// Only used when empty < median < full, so the difference fits the code width.
	assign diff = CODE_BITS'(med_ext - lo_ext);
	assign numer = NUM_BITS'(diff) * NUM_BITS'(PERCENT_MAX);
	assign div_start = (state_q == ST_CALC) && (hi_ext > lo_ext) && (med_ext > lo_ext)
		&& (med_ext < hi_ext);

	bmg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (numer),
		.den    (full_q - empty_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= RESET_EMPTY;
			full_q <= RESET_FULL;
		end else if (wr_en) begin
			if (wr_index == REG_EMPTY_CODE) begin
				empty_q <= wr_data;
			end else if (wr_index == REG_FULL_CODE) begin
				full_q <= wr_data;
			end
		end
	end

	// Ring memory: written on a sample transaction, read at most once per scan cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[slot_q] <= SAMPLE_BITS'(samples.sample_code);
		end
		if (state_q == ST_SCAN && addr_q < LAST_ADDR) begin
			rd_s1 <= ring_mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q <= '0;
			rdv_s1 <= 1'b0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN) && (addr_q < LAST_ADDR);
			if (state_q == ST_SCAN && addr_q < LAST_ADDR) begin
				rdv_s1 <= valid_q[addr_q[AW-1:0]];
			end
			if (accept) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// Control sequence and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			addr_q <= '0;
			cnt_q <= '0;
			rank_q <= '0;
			prefix_q <= '0;
			mask_q <= '0;
			bit_q <= '0;
			median_q <= '0;
			pct_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						addr_q <= '0;
						cnt_q <= '0;
						rank_q <= RANK;
						prefix_q <= '0;
						mask_q <= '0;
						bit_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						// All entries of this bit pass counted: decide the bit.
						addr_q <= '0;
						cnt_q <= '0;
						if (rank_q >= total) begin
							prefix_q <= prefix_q | bit_q;
							rank_q <= rank_q - total;
						end
						mask_q <= mask_q | bit_q;
						bit_q <= bit_q >> 1;
						if (bit_q[0]) begin
							state_q <= ST_CALC;
						end
					end else begin
						addr_q <= addr_q + 1'b1;
						cnt_q <= total;
					end
				end
				ST_CALC: begin
					median_q <= CODE_BITS'(prefix_q);
					if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						// Degenerate range or median at or below empty gives zero,
						// at or above full gives the maximum.
						pct_q <= (hi_ext > lo_ext && med_ext >= hi_ext) ? PERCENT_MAX : '0;
						out_vld_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pct_q <= div_quo;
						out_vld_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (gauge.ready) begin
						out_vld_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					out_vld_q <= 1'b0;
				end
			endcase
		end
	end

	assign gauge.valid = out_vld_q;
	assign gauge.median_code = median_q;
	assign gauge.charge_percent = pct_q;

	`BMG_ASSERT_NOW(a_no_overlap, samples.ready, !gauge.valid, "input ready while a result is held")
	`BMG_ASSERT_NOW(a_pct_range, gauge.valid, gauge.charge_percent <= PERCENT_MAX, "percent above maximum")
	`BMG_ASSERT_NOW(a_degenerate, gauge.valid && full_q <= empty_q, gauge.charge_percent == '0, "degenerate range not zero")
	`BMG_ASSERT_NEXT(a_scan_start, accept, state_q == ST_SCAN && addr_q == '0, "scan did not start")
	`BMG_ASSERT_NOW(a_div_done_state, div_done, state_q == ST_DIV, "divider finished outside its state")
endmodule

/* bench/tb_top.sv */
// Self-checking bench for the battery median gauge unit.
// Needs bmg_pkg, the bmg_sample_if / bmg_gauge_if interfaces and the RTL top.
`timescale 1ns / 100ps

module tb_top;
	import bmg_pkg::*;

	localparam int WINDOW = 50;
	localparam int SAMPLE_BITS = 12;
	// Allowance for one item inside the block, used for the final wait.
	localparam int ITEM_CYCLES = SAMPLE_BITS * (WINDOW + 1) + 11;
	localparam int RANDOM_ITEMS = 1780;
	localparam int HOLD_OFF_CYCLES = 2500;

	typedef struct packed {
		code_t median_code;
		pct_t charge_percent;
	} gauge_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_BITS-1:0] wr_index;
	code_t wr_data;

	bmg_sample_if samples ();
	bmg_gauge_if gauge ();

	battery_median_gauge_unit #(
		.WINDOW(WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.samples(samples),
		.gauge(gauge)
	);

	// Shadow of the block: sample history, write position and the two codes.
	code_t history[WINDOW];
	int unsigned slot;
	code_t empty_sh;
	code_t full_sh;

	code_t pending_samples[$];
	gauge_t gauge_due[$];
	int unsigned mismatches;
	int unsigned results_seen;
	bit sample_taken;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned hold_off;
	bit hold_off_done;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Median of the history: ascending order statistic at WINDOW/2. The
	// percentage truncates toward zero, so a median below empty gives a
	// non-positive quotient that clamps to zero.
	function automatic gauge_t gauge_of_history();
		code_t sorted[WINDOW];
		code_t tmp;
		gauge_t g;
		int pct;
		sorted = history;
		for (int i = 1; i < WINDOW; i++) begin
			tmp = sorted[i];
			for (int j = i; j > 0 && sorted[j-1] > tmp; j--) begin
				sorted[j] = sorted[j-1];
				sorted[j-1] = tmp;
			end
		end
		g.median_code = sorted[WINDOW/2];
		if (full_sh <= empty_sh) begin
			pct = 0;
		end else begin
			pct = ((int'(g.median_code) - int'(empty_sh)) * 100) /
				(int'(full_sh) - int'(empty_sh));
			if (pct < 0) pct = 0;
			if (pct > 100) pct = 100;
		end
		g.charge_percent = pct_t'(pct);
		return g;
	endfunction

	// Mostly short gaps, some mid-length, a few long; three times in five
	// the next stretch runs back to back.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// Driver: a new sample is offered only once the previous transaction has
	// been taken, so valid never drops while an item is waiting.
	initial begin
		samples.valid = 1'b0;
		samples.sample_code = '0;
		send_gap = 0;
	end

	always @(negedge clk) begin
		if (!samples.valid || sample_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				samples.valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				samples.sample_code <= pending_samples.pop_front();
				samples.valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				samples.valid <= 1'b0;
			end
		end
	end

	// Accepted sample transactions update the shadow and queue the answer.
	always @(posedge clk) begin
		sample_taken = samples.valid && samples.ready && arst_n;
		if (sample_taken) begin
			history[slot] = samples.sample_code;
			slot = (slot + 1 == WINDOW) ? 0 : slot + 1;
			gauge_due.push_back(gauge_of_history());
		end
	end

	// Receiver ready. Once, after a few hundred results, it holds off for a
	// long stretch so the block fills up and stalls its sample input.
	initial begin
		gauge.ready = 1'b0;
		recv_stall = 0;
		hold_off = 0;
		hold_off_done = 1'b0;
	end

	always @(negedge clk) begin
		if (!hold_off_done && results_seen == 300) begin
			hold_off_done <= 1'b1;
			hold_off <= HOLD_OFF_CYCLES;
			gauge.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			gauge.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			gauge.ready <= 1'b0;
		end else begin
			gauge.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap();
		end
	end

	// Monitor: each result transaction is held against the oldest answer due.
	always @(posedge clk) begin
		gauge_t due;
		if (arst_n && gauge.valid && gauge.ready) begin
			results_seen <= results_seen + 1;
			if (gauge_due.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result: median %0d charge %0d",
						gauge.median_code, gauge.charge_percent);
			end else begin
				due = gauge_due.pop_front();
				if (gauge.median_code !== due.median_code ||
						gauge.charge_percent !== due.charge_percent) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: median exp %0d got %0d, charge exp %0d got %0d",
							due.median_code, gauge.median_code,
							due.charge_percent, gauge.charge_percent);
				end
			end
		end
	end

	// Register write, made at the falling edge while the block is idle. The
	// shadow follows only for indexes that name a register.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input code_t value);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
		if (idx == REG_EMPTY_CODE) empty_sh = value;
		else if (idx == REG_FULL_CODE) full_sh = value;
	endtask

	task automatic set_codes(input code_t lo, input code_t hi);
		write_reg(REG_EMPTY_CODE, lo);
		write_reg(REG_FULL_CODE, hi);
	endtask

	task automatic wait_drained();
		wait (pending_samples.size() == 0 && !samples.valid && gauge_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// Random samples. Most come in shaped runs, some of them around the
	// calibration points; the rest are uniform over the whole code range.
	task automatic queue_random(input int unsigned count);
		int unsigned kind;
		int unsigned run;
		code_t base;
		int unsigned n;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 9);
			run = $urandom_range(1, 60);
			base = code_t'($urandom_range(0, 4095));
			if (kind < 2) base = empty_sh;
			else if (kind < 4) base = full_sh;
			for (int unsigned k = 0; k < run && n < count; k++) begin
				if (kind < 6)
					pending_samples.push_back(code_t'(int'(base) +
						$urandom_range(0, 64) - 32));
				else if (kind == 6)
					pending_samples.push_back(base);
				else
					pending_samples.push_back(code_t'($urandom_range(0, 4095)));
				n++;
			end
		end
	endtask

	initial begin
		mismatches = 0;
		results_seen = 0;
		slot = 0;
		foreach (history[i]) history[i] = '0;
		empty_sh = RESET_EMPTY;
		full_sh = RESET_FULL;
		wr_en = 1'b0;
		wr_index = REG_EMPTY_CODE;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset calibration: the ring still holds the reset zeros,
		// so the median stays at zero until half of it holds nonzero samples.
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'hAAA);
		pending_samples.push_back(12'h555);
		for (int i = 0; i < 24; i++) pending_samples.push_back(12'd2360 + 12'(i));
		wait_drained();

		// Full below empty, then equal: the percentage must stay at zero.
		// Writes to the two unused indexes must change nothing.
		set_codes(12'd3000, 12'd1000);
		write_reg(2'd2, 12'd0);
		write_reg(2'd3, 12'd4095);
		for (int i = 0; i < 8; i++) pending_samples.push_back(12'd4095);
		wait_drained();
		set_codes(12'd2000, 12'd2000);
		queue_random(80);
		wait_drained();

		// Widest span, one code wide, the reset span where both clamps are reached,
		// one code wide at the top of the range and a random span.
		set_codes(12'd0, 12'd4095);
		queue_random(RANDOM_ITEMS / 4);
		wait_drained();
		set_codes(12'd2047, 12'd2048);
		queue_random(RANDOM_ITEMS / 8);
		wait_drained();
		set_codes(RESET_EMPTY, RESET_FULL);
		queue_random(RANDOM_ITEMS / 4);
		wait_drained();
		set_codes(12'd4094, 12'd4095);
		queue_random(RANDOM_ITEMS / 8);
		wait_drained();
		set_codes(code_t'($urandom_range(0, 2047)), code_t'($urandom_range(2048, 4095)));
		queue_random(RANDOM_ITEMS / 4);
		wait_drained();

		// Let any late extra result show up before the verdict.
		repeat (2 * ITEM_CYCLES) @(posedge clk);
		if (mismatches == 0 && gauge_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end
endmodule
